FILE: hdl/touch_gesture_detector_macros.svh
// assertion helpers for the touch gesture detector
`ifndef TOUCH_GESTURE_DETECTOR_MACROS_SVH
`define TOUCH_GESTURE_DETECTOR_MACROS_SVH

`define TGD_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TGD_ASSERT(lbl, prop, msg) \
   `TGD_ASSERT_ON(lbl, clock, reset, prop, msg)

`endif

FILE: hdl/tgd_pkg.sv
package tgd_pkg;

   localparam int RAW_BITS       = 12;
   localparam int TIME_BITS      = 32;
   localparam int CAL_BITS       = 12;
   localparam int HOLD_BITS      = 16;
   localparam int ORIENT_BITS    = 3;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_X_MIN     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_X_MAX     = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_Y_MIN     = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_Y_MAX     = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIENTATION   = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_PRESS_MS = 4'd7;

   localparam logic [CAL_BITS-1:0]    RST_CAL_X_MIN     = 12'd300;
   localparam logic [CAL_BITS-1:0]    RST_CAL_X_MAX     = 12'd3600;
   localparam logic [CAL_BITS-1:0]    RST_CAL_Y_MIN     = 12'd400;
   localparam logic [CAL_BITS-1:0]    RST_CAL_Y_MAX     = 12'd3700;
   localparam logic [ORIENT_BITS-1:0] RST_ORIENTATION   = 3'd5;
   localparam logic [CAL_BITS-1:0]    RST_SCREEN_WIDTH  = 12'd320;
   localparam logic [CAL_BITS-1:0]    RST_SCREEN_HEIGHT = 12'd240;
   localparam logic [HOLD_BITS-1:0]   RST_LONG_PRESS_MS = 16'd500;

   localparam logic [2:0] EV_DOWN  = 3'd0;
   localparam logic [2:0] EV_MOVE  = 3'd1;
   localparam logic [2:0] EV_LONG  = 3'd2;
   localparam logic [2:0] EV_UP    = 3'd3;
   localparam logic [2:0] EV_CLICK = 3'd4;

   typedef struct packed {
      logic                 touched;
      logic [RAW_BITS-1:0]  raw_x;
      logic [RAW_BITS-1:0]  raw_y;
      logic [TIME_BITS-1:0] time_ms;
   } tgd_req_type;

   typedef struct packed {
      logic [2:0]   event_kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic         last_of_run;
   } tgd_rsp_type;

endpackage

FILE: hdl/tgd_divider.sv
module tgd_divider #(
   parameter int NUM_WIDTH = 24,
   parameter int DEN_WIDTH = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0] den,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);

   // restoring division, two quotient bits per cycle; NUM_WIDTH must be even
   localparam int STEPS = NUM_WIDTH / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;

   logic [DEN_WIDTH:0] r1, r1s, r2, r2s;
   logic               ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[NUM_WIDTH-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? r1 - {1'b0, den_ff} : r1;
      r2  = {r1s[DEN_WIDTH-1:0], quo_ff[NUM_WIDTH-2]};
      ge2 = r2 >= {1'b0, den_ff};
      r2s = ge2 ? r2 - {1'b0, den_ff} : r2;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = r2s[DEN_WIDTH-1:0];
         quo_in = {quo_ff[NUM_WIDTH-3:0], ge1, ge2};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/touch_gesture_detector.sv
// Touch gesture detector.
// req channel: one panel sample per transaction (touched, raw_x, raw_y, time_ms).
// rsp channel: zero, one or two gesture events per sample (down, move, long
// press, up, click); last_of_run marks the final event of a sample.
// csr channel: register index and data; csr_ready is always high. Write only
// while the block is idle.
// A touched sample maps both axes through one shared multiply step and one
// two-bit-per-cycle divider, used first for X, then for Y: it passes S_MUL,
// S_GO and S_WAIT once per axis, then S_EVAL and S_EMIT0 (NUM_W, the padded
// numerator width, is 24 at the default widths). A release sample goes from
// S_IDLE straight to S_EVAL. req_ready is high only between samples.
// A sample is accepted only once the previous one has handed its events to
// the output register.
// Events leave through an output register, so the next sample is accepted and
// processed while the last event waits. If rsp_ready stays low, a sample with
// two events stalls until the first is taken.
// Synchronous reset restores calibration defaults, clears the press state and
// drops any pending event.
module touch_gesture_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tgd_pkg::tgd_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tgd_pkg::tgd_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tgd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tgd_pkg::*;

   localparam int OP_W   = (RAW_BITS > CAL_BITS) ? RAW_BITS : CAL_BITS;
   localparam int NUM_W  = 2 * ((OP_W + CAL_BITS + 1) / 2);
   localparam int PROD_W = OP_W + CAL_BITS + 2;
   localparam int QW     = NUM_W + 2;
   localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
   localparam logic signed [QW-1:0] SAT_LO = QW'(-32768);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_GO    = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_EMIT0 = 3'd5;
   localparam logic [2:0] S_EMIT1 = 3'd6;

   logic [CAL_BITS-1:0]    cal_x_min_ff, cal_x_max_ff, cal_y_min_ff, cal_y_max_ff;
   logic [ORIENT_BITS-1:0] orient_ff;
   logic [CAL_BITS-1:0]    width_ff, height_ff;
   logic [HOLD_BITS-1:0]   hold_ff;

   logic [2:0]  state_ff, state_in;
   logic        axis_ff, axis_in;
   logic        pressed_ff, pressed_in;
   logic        long_fired_ff, long_fired_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic signed [15:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [1:0]  n_ff, n_in;
   logic        rsp_valid_ff, rsp_valid_in;

   tgd_req_type          sample_ff, sample_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [OP_W:0]     den_ff, den_in;
   logic signed [15:0]       x_ff, x_in, y_ff, y_in;
   tgd_rsp_type          ev0_ff, ev0_in, ev1_ff, ev1_in;
   tgd_rsp_type          rsp_data_ff, rsp_data_in;

   logic [RAW_BITS-1:0]  a_sel;
   logic [CAL_BITS-1:0]  lo_sel, hi_sel, size_sel;
   logic                 mirror_sel;
   logic signed [OP_W:0] diff;
   logic [PROD_W-1:0]    prod_mag;
   logic [OP_W:0]        den_mag;
   logic                 div_start, div_done;
   logic [NUM_W-1:0]     quo;
   logic signed [QW-1:0] q_s, mirrored;
   logic signed [15:0]   sat;
   logic [TIME_BITS-1:0] elapsed;
   logic                 hold_reached, moved, fire_long, slot_free;

   tgd_divider #(
      .NUM_WIDTH(NUM_W),
      .DEN_WIDTH(OP_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (prod_mag[NUM_W-1:0]),
      .den     (den_mag[OP_W-1:0]),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      if (axis_ff ^ orient_ff[0]) begin
         a_sel = sample_ff.raw_y;
      end else begin
         a_sel = sample_ff.raw_x;
      end
      lo_sel     = axis_ff ? cal_y_min_ff : cal_x_min_ff;
      hi_sel     = axis_ff ? cal_y_max_ff : cal_x_max_ff;
      size_sel   = axis_ff ? height_ff : width_ff;
      mirror_sel = axis_ff ? orient_ff[2] : orient_ff[1];

      diff    = signed'({1'b0, OP_W'(a_sel)}) - signed'({1'b0, OP_W'(lo_sel)});
      prod_in = PROD_W'(diff) * PROD_W'(signed'({1'b0, size_sel}));
      den_in  = signed'({1'b0, OP_W'(hi_sel)}) - signed'({1'b0, OP_W'(lo_sel)});

      prod_mag  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      den_mag   = den_ff[OP_W] ? (OP_W+1)'(-den_ff) : (OP_W+1)'(den_ff);
      div_start = (state_ff == S_GO);

      q_s = signed'({2'b00, quo});
      if (prod_ff[PROD_W-1] ^ den_ff[OP_W]) begin
         q_s = -q_s;
      end
      if (den_ff == '0) begin
         q_s = '0;
      end
      mirrored = mirror_sel ? signed'(QW'(size_sel)) - q_s : q_s;
      if (mirrored > SAT_HI) begin
         sat = 16'sh7FFF;
      end else if (mirrored < SAT_LO) begin
         sat = -16'sh8000;
      end else begin
         sat = mirrored[15:0];
      end

      elapsed      = sample_ff.time_ms - press_start_ff;
      hold_reached = elapsed >= TIME_BITS'(hold_ff);
      moved        = (x_ff != prev_x_ff) || (y_ff != prev_y_ff);
      fire_long    = !long_fired_ff && hold_reached;
      slot_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      pressed_in     = pressed_ff;
      long_fired_in  = long_fired_ff;
      press_start_in = press_start_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      n_in           = n_ff;
      sample_in      = sample_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      ev0_in         = ev0_ff;
      ev1_in         = ev1_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_data;
               axis_in   = 1'b0;
               state_in  = req_data.touched ? S_MUL : S_EVAL;
            end
         end
         S_MUL: begin
            state_in = S_GO;
         end
         S_GO: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (axis_ff) begin
                  y_in     = sat;
                  state_in = S_EVAL;
               end else begin
                  x_in     = sat;
                  axis_in  = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_EVAL: begin
            n_in     = 2'd0;
            state_in = S_EMIT0;
            ev0_in   = '{event_kind: EV_DOWN, pos_x: x_ff, pos_y: y_ff, last_of_run: 1'b1};
            ev1_in   = '{event_kind: EV_MOVE, pos_x: x_ff, pos_y: y_ff, last_of_run: 1'b1};
            if (sample_ff.touched) begin
               if (!pressed_ff) begin
                  n_in           = 2'd1;
                  press_start_in = sample_ff.time_ms;
                  long_fired_in  = 1'b0;
               end else begin
                  if (fire_long) begin
                     ev0_in.event_kind  = EV_LONG;
                     ev0_in.last_of_run = !moved;
                     n_in               = moved ? 2'd2 : 2'd1;
                     long_fired_in      = 1'b1;
                  end else if (moved) begin
                     ev0_in.event_kind = EV_MOVE;
                     n_in              = 2'd1;
                  end
               end
               prev_x_in  = x_ff;
               prev_y_in  = y_ff;
               pressed_in = 1'b1;
            end else begin
               ev0_in = '{event_kind: EV_UP, pos_x: prev_x_ff, pos_y: prev_y_ff,
                          last_of_run: 1'b1};
               ev1_in = '{event_kind: EV_CLICK, pos_x: prev_x_ff, pos_y: prev_y_ff,
                          last_of_run: 1'b1};
               if (pressed_ff) begin
                  if (!long_fired_ff && !hold_reached) begin
                     ev0_in.last_of_run = 1'b0;
                     n_in               = 2'd2;
                  end else begin
                     n_in = 2'd1;
                  end
               end
               pressed_in    = 1'b0;
               long_fired_in = 1'b0;
            end
         end
         S_EMIT0: begin
            if (n_ff == 2'd0) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ev0_ff;
               state_in     = (n_ff == 2'd2) ? S_EMIT1 : S_IDLE;
            end
         end
         S_EMIT1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ev1_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_min_ff <= RST_CAL_X_MIN;
         cal_x_max_ff <= RST_CAL_X_MAX;
         cal_y_min_ff <= RST_CAL_Y_MIN;
         cal_y_max_ff <= RST_CAL_Y_MAX;
         orient_ff    <= RST_ORIENTATION;
         width_ff     <= RST_SCREEN_WIDTH;
         height_ff    <= RST_SCREEN_HEIGHT;
         hold_ff      <= RST_LONG_PRESS_MS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CAL_X_MIN:     cal_x_min_ff <= csr_data[CAL_BITS-1:0];
            REG_CAL_X_MAX:     cal_x_max_ff <= csr_data[CAL_BITS-1:0];
            REG_CAL_Y_MIN:     cal_y_min_ff <= csr_data[CAL_BITS-1:0];
            REG_CAL_Y_MAX:     cal_y_max_ff <= csr_data[CAL_BITS-1:0];
            REG_ORIENTATION:   orient_ff    <= csr_data[ORIENT_BITS-1:0];
            REG_SCREEN_WIDTH:  width_ff     <= csr_data[CAL_BITS-1:0];
            REG_SCREEN_HEIGHT: height_ff    <= csr_data[CAL_BITS-1:0];
            REG_LONG_PRESS_MS: hold_ff      <= csr_data[HOLD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         axis_ff        <= 1'b0;
         pressed_ff     <= 1'b0;
         long_fired_ff  <= 1'b0;
         press_start_ff <= '0;
         prev_x_ff      <= -16'sd1;
         prev_y_ff      <= -16'sd1;
         n_ff           <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         pressed_ff     <= pressed_in;
         long_fired_ff  <= long_fired_in;
         press_start_ff <= press_start_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         n_ff           <= n_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ev0_ff      <= ev0_in;
      ev1_ff      <= ev1_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_MUL) begin
         prod_ff <= prod_in;
         den_ff  <= den_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: hdl/tgd_checker.sv
`include "touch_gesture_detector_macros.svh"

module tgd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tgd_pkg::tgd_rsp_type rsp_data
);
   import tgd_pkg::*;

   `TGD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp changed while stalled")
   `TGD_ASSERT(a_kind_range, rsp_valid |-> rsp_data.event_kind <= EV_CLICK, "bad event kind")
   `TGD_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "ready right after a sample")
   `TGD_ASSERT(a_run_continues, rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid, "second event missing")
   `TGD_ASSERT(a_click_last, rsp_valid && rsp_data.event_kind == EV_CLICK |-> rsp_data.last_of_run, "click not last")

endmodule

bind touch_gesture_detector tgd_checker u_tgd_checker (.*);

FILE: verif/touch_gesture_detector_test.sv
`timescale 1ns / 1ps

module touch_gesture_detector_test;
   import tgd_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 240;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   tgd_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   tgd_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   touch_gesture_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow registers and press state
   logic [CAL_BITS-1:0]    cfg_x_min, cfg_x_max, cfg_y_min, cfg_y_max;
   logic [ORIENT_BITS-1:0] cfg_orient;
   logic [CAL_BITS-1:0]    cfg_width, cfg_height;
   logic [HOLD_BITS-1:0]   cfg_hold;
   logic                   is_pressed;
   logic                   long_done;
   logic [TIME_BITS-1:0]   hold_start;
   logic signed [15:0]     last_x, last_y;

   tgd_rsp_type expected_events[$];
   int error_count;
   int items_sent;
   int send_idle_pct;
   int rsp_stall_pct;
   logic [TIME_BITS-1:0] now_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic signed [15:0] scale_axis(logic [CAL_BITS-1:0] raw,
                                                    logic [CAL_BITS-1:0] lo,
                                                    logic [CAL_BITS-1:0] hi,
                                                    logic [CAL_BITS-1:0] size,
                                                    logic mirror);
      longint v;
      longint den;
      v = 0;
      den = longint'(hi) - longint'(lo);
      if (den != 0) v = ((longint'(raw) - longint'(lo)) * longint'(size)) / den;
      if (mirror) v = longint'(size) - v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic tgd_rsp_type gesture_event(logic [2:0] kind, logic signed [15:0] x,
                                                 logic signed [15:0] y);
      tgd_rsp_type e;
      e.event_kind = kind;
      e.pos_x = x;
      e.pos_y = y;
      e.last_of_run = 1'b0;
      return e;
   endfunction

   task automatic predict_events(input tgd_req_type s);
      logic [RAW_BITS-1:0] ax, ay;
      logic signed [15:0] x, y;
      logic [TIME_BITS-1:0] elapsed;
      tgd_rsp_type evs[$];
      elapsed = s.time_ms - hold_start;
      if (s.touched) begin
         ax = cfg_orient[0] ? s.raw_y : s.raw_x;
         ay = cfg_orient[0] ? s.raw_x : s.raw_y;
         x = scale_axis(ax, cfg_x_min, cfg_x_max, cfg_width, cfg_orient[1]);
         y = scale_axis(ay, cfg_y_min, cfg_y_max, cfg_height, cfg_orient[2]);
         if (!is_pressed) begin
            evs.push_back(gesture_event(EV_DOWN, x, y));
            hold_start = s.time_ms;
            long_done = 1'b0;
         end else begin
            if (!long_done && elapsed >= TIME_BITS'(cfg_hold)) begin
               evs.push_back(gesture_event(EV_LONG, x, y));
               long_done = 1'b1;
            end
            if (x != last_x || y != last_y) evs.push_back(gesture_event(EV_MOVE, x, y));
         end
         last_x = x;
         last_y = y;
         is_pressed = 1'b1;
      end else begin
         if (is_pressed) begin
            evs.push_back(gesture_event(EV_UP, last_x, last_y));
            if (!long_done && elapsed < TIME_BITS'(cfg_hold))
               evs.push_back(gesture_event(EV_CLICK, last_x, last_y));
         end
         is_pressed = 1'b0;
         long_done = 1'b0;
      end
      if (evs.size() > 0) evs[evs.size()-1].last_of_run = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   task automatic send_sample(input logic touch, input logic [RAW_BITS-1:0] rx,
                              input logic [RAW_BITS-1:0] ry, input logic [TIME_BITS-1:0] t);
      tgd_req_type s;
      s.touched = touch;
      s.raw_x = rx;
      s.raw_y = ry;
      s.time_ms = t;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      if (touch || is_pressed) items_sent++;
      predict_events(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_CAL_X_MIN:     cfg_x_min = val[CAL_BITS-1:0];
         REG_CAL_X_MAX:     cfg_x_max = val[CAL_BITS-1:0];
         REG_CAL_Y_MIN:     cfg_y_min = val[CAL_BITS-1:0];
         REG_CAL_Y_MAX:     cfg_y_max = val[CAL_BITS-1:0];
         REG_ORIENTATION:   cfg_orient = val[ORIENT_BITS-1:0];
         REG_SCREEN_WIDTH:  cfg_width = val[CAL_BITS-1:0];
         REG_SCREEN_HEIGHT: cfg_height = val[CAL_BITS-1:0];
         REG_LONG_PRESS_MS: cfg_hold = val[HOLD_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [CAL_BITS-1:0] x_lo, input logic [CAL_BITS-1:0] x_hi,
                               input logic [CAL_BITS-1:0] y_lo, input logic [CAL_BITS-1:0] y_hi,
                               input logic [ORIENT_BITS-1:0] orient,
                               input logic [CAL_BITS-1:0] w, input logic [CAL_BITS-1:0] h,
                               input logic [HOLD_BITS-1:0] hold);
      write_reg(REG_CAL_X_MIN, CSR_DATA_BITS'(x_lo));
      write_reg(REG_CAL_X_MAX, CSR_DATA_BITS'(x_hi));
      write_reg(REG_CAL_Y_MIN, CSR_DATA_BITS'(y_lo));
      write_reg(REG_CAL_Y_MAX, CSR_DATA_BITS'(y_hi));
      write_reg(REG_ORIENTATION, CSR_DATA_BITS'(orient));
      write_reg(REG_SCREEN_WIDTH, CSR_DATA_BITS'(w));
      write_reg(REG_SCREEN_HEIGHT, CSR_DATA_BITS'(h));
      write_reg(REG_LONG_PRESS_MS, CSR_DATA_BITS'(hold));
      csr_valid <= 1'b0;
   endtask

   task automatic pick_bounds(output logic [CAL_BITS-1:0] lo, output logic [CAL_BITS-1:0] hi);
      case ($urandom_range(7))
         0: begin
            lo = CAL_BITS'($urandom_range(4095));
            hi = lo;
         end
         1: begin
            lo = CAL_BITS'($urandom_range(2100, 4095));
            hi = CAL_BITS'($urandom_range(0, 2000));
         end
         2: begin
            lo = 0;
            hi = 4095;
         end
         3: begin
            lo = 4095;
            hi = 0;
         end
         default: begin
            lo = CAL_BITS'($urandom_range(0, 2000));
            hi = CAL_BITS'($urandom_range(2100, 4095));
         end
      endcase
   endtask

   task automatic random_config();
      logic [CAL_BITS-1:0] xl, xh, yl, yh, w, h;
      logic [HOLD_BITS-1:0] hold;
      pick_bounds(xl, xh);
      pick_bounds(yl, yh);
      case ($urandom_range(3))
         0: w = 4095;
         1: w = 1;
         default: w = CAL_BITS'($urandom_range(1, 4095));
      endcase
      case ($urandom_range(3))
         0: h = 4095;
         1: h = 1;
         default: h = CAL_BITS'($urandom_range(1, 4095));
      endcase
      case ($urandom_range(5))
         0: hold = 16'hFFFF;
         1: hold = 1;
         default: hold = HOLD_BITS'($urandom_range(1, 3000));
      endcase
      program_regs(xl, xh, yl, yh, ORIENT_BITS'($urandom_range(7)), w, h, hold);
   endtask

   task automatic random_gesture();
      logic [RAW_BITS-1:0] rx, ry;
      logic [TIME_BITS-1:0] press_t;
      int unsigned dur;
      int held;
      if ($urandom_range(3) == 0) now_ms = $urandom();
      rx = RAW_BITS'($urandom_range(4095));
      ry = RAW_BITS'($urandom_range(4095));
      press_t = now_ms;
      send_sample(1'b1, rx, ry, press_t);
      held = $urandom_range(0, 6);
      case ($urandom_range(3))
         0: dur = (cfg_hold == 0) ? 0 : $urandom_range(0, cfg_hold - 1);
         1: dur = int'(cfg_hold) + $urandom_range(2) - ((cfg_hold == 0) ? 0 : 1);
         2: dur = int'(cfg_hold) + $urandom_range(5000);
         default: dur = $urandom_range(100);
      endcase
      for (int k = 0; k < held; k++) begin
         case ($urandom_range(3))
            0: begin
               rx = RAW_BITS'($urandom_range(4095));
               ry = RAW_BITS'($urandom_range(4095));
            end
            1: begin
               rx = rx ^ RAW_BITS'($urandom_range(3));
               ry = ry ^ RAW_BITS'($urandom_range(3));
            end
            default: ;
         endcase
         send_sample(1'b1, rx, ry, press_t + (dur * (k + 1)) / held);
      end
      send_sample(1'b0, RAW_BITS'($urandom_range(4095)), RAW_BITS'($urandom_range(4095)),
                  press_t + dur);
      now_ms = press_t + dur + $urandom_range(50);
   endtask

   task automatic test_default_tap();
      send_sample(1'b0, 12'd0, 12'd0, 32'd10);
      send_sample(1'b1, 12'd0, 12'd0, 32'd1000);
      send_sample(1'b1, 12'd0, 12'd0, 32'd1100);
      send_sample(1'b1, 12'd4095, 12'd4095, 32'd1200);
      send_sample(1'b0, 12'd4095, 12'd4095, 32'd1300);
      drain();
   endtask

   task automatic test_long_press();
      program_regs(RST_CAL_X_MIN, RST_CAL_X_MAX, RST_CAL_Y_MIN, RST_CAL_Y_MAX,
                   3'd0, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, 16'd100);
      // press straddles the time wrap
      send_sample(1'b1, 12'd2000, 12'd2000, 32'hFFFF_FFC0);
      send_sample(1'b1, 12'd2000, 12'd2000, 32'hFFFF_FFC0 + 32'd99);
      send_sample(1'b1, 12'd2000, 12'd2000, 32'hFFFF_FFC0 + 32'd100);
      send_sample(1'b1, 12'd2500, 12'd1500, 32'hFFFF_FFC0 + 32'd150);
      send_sample(1'b0, 12'd0, 12'd0, 32'hFFFF_FFC0 + 32'd200);
      send_sample(1'b1, 12'd4095, 12'd0, 32'd5000);
      send_sample(1'b0, 12'd0, 12'd4095, 32'd5099);
      drain();
   endtask

   task automatic test_saturation();
      program_regs(12'd0, 12'd1, 12'd4095, 12'd4094, 3'd2, 12'd4095, 12'd4095, 16'hFFFF);
      send_sample(1'b1, 12'd4095, 12'd0, 32'd0);
      send_sample(1'b1, 12'd0, 12'd4095, 32'd1);
      send_sample(1'b0, 12'd0, 12'd0, 32'd2);
      drain();
   endtask

   task automatic test_zero_spans();
      program_regs(12'd2000, 12'd2000, 12'd4095, 12'd0, 3'd7, 12'd0, 12'd0, 16'd0);
      send_sample(1'b1, 12'd123, 12'd3000, 32'd77);
      send_sample(1'b1, 12'd4095, 12'd0, 32'd77);
      send_sample(1'b0, 12'd0, 12'd0, 32'd77);
      drain();
   endtask

   task automatic test_random_traffic();
      int phase_end;
      for (int mode = 0; mode < 4; mode++) begin
         for (int rep = 0; rep < 2; rep++) begin
            case (mode)
               0: begin
                  send_idle_pct = 0;
                  rsp_stall_pct = 0;
               end
               1: begin
                  send_idle_pct = 80;
                  rsp_stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  rsp_stall_pct = 80;
               end
               default: begin
                  send_idle_pct = 9;
                  rsp_stall_pct = 9;
               end
            endcase
            random_config();
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
               case ($urandom_range(9))
                  0: send_sample(1'b0, RAW_BITS'($urandom_range(4095)),
                                 RAW_BITS'($urandom_range(4095)), $urandom());
                  1: send_sample(1'b1, RAW_BITS'($urandom_range(4095)),
                                 RAW_BITS'($urandom_range(4095)), $urandom());
                  default: random_gesture();
               endcase
            end
            drain();
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      tgd_rsp_type want;
      logic bad;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected transaction kind=%0d x=%0d y=%0d last=%0d", $time,
                     rsp_data.event_kind, rsp_data.pos_x, rsp_data.pos_y, rsp_data.last_of_run);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            bad = 1'b0;
            if (rsp_data.event_kind !== want.event_kind) begin
               $display("%0t: event_kind expected %0d actual %0d", $time, want.event_kind,
                        rsp_data.event_kind);
               bad = 1'b1;
            end
            if (rsp_data.pos_x !== want.pos_x) begin
               $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x,
                        rsp_data.pos_x);
               bad = 1'b1;
            end
            if (rsp_data.pos_y !== want.pos_y) begin
               $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y,
                        rsp_data.pos_y);
               bad = 1'b1;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run expected %0d actual %0d", $time, want.last_of_run,
                        rsp_data.last_of_run);
               bad = 1'b1;
            end
            if (bad) error_count++;
         end
      end
   end

   initial begin
      error_count = 0;
      items_sent = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      now_ms = 0;
      cfg_x_min = RST_CAL_X_MIN;
      cfg_x_max = RST_CAL_X_MAX;
      cfg_y_min = RST_CAL_Y_MIN;
      cfg_y_max = RST_CAL_Y_MAX;
      cfg_orient = RST_ORIENTATION;
      cfg_width = RST_SCREEN_WIDTH;
      cfg_height = RST_SCREEN_HEIGHT;
      cfg_hold = RST_LONG_PRESS_MS;
      is_pressed = 1'b0;
      long_done = 1'b0;
      hold_start = '0;
      last_x = -16'sd1;
      last_y = -16'sd1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_tap();
      test_long_press();
      test_saturation();
      test_zero_spans();
      test_random_traffic();
      drain();

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: touch_gesture_detector.f
+incdir+hdl
hdl/tgd_pkg.sv
hdl/tgd_divider.sv
hdl/touch_gesture_detector.sv
hdl/tgd_checker.sv
verif/touch_gesture_detector_test.sv
